[sv/tsc_pkg.sv]
package tsc_pkg;

  localparam int ALU_W = 65;

  localparam logic [63:0] PERIOD_LIMIT = 64'h0000_0000_8000_0000;
  localparam logic [31:0] MUL_IDENTITY = 32'h8000_0000;

  typedef logic signed [9:0] shift_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

endpackage

[sv/tsc_time_scale_calibrator_unit.sv]
// time-scale calibrator
// input channel in_*: one request per calibration, tdata carries tick_count,
// period_ns and delta_value. result channel out_*: tdata carries the forward
// and reciprocal scales and both converted deltas, tuser carries bad_input.
// a request is taken only while the block is idle (in_tready high); it is then
// worked through by one shared 65-bit subtract/compare unit, one step per
// cycle, and a registered 32x32 multiplier.
// from accept to result valid the block works through the prescale, tick
// normalize and shift-up steps, two 32-step restoring divisions, the reciprocal
// normalize steps and the four partial products. a bad request (zero period or
// zero normalized ticks) skips the divisions and returns all-zero fields with
// bad_input set. the block returns to idle when the result is loaded, so the
// next request can be taken from the cycle after the load.
// the result sits in an output register; a new request may be accepted while it
// waits, and the block holds its next result until out_tready frees the slot.
// reset (rst_n low, synchronous) returns the block to idle and drops out_tvalid.
module tsc_time_scale_calibrator_unit import tsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // tick_count, period_ns, delta_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [207:0] out_tdata,  // scale_mul, scale_shift, inverse_mul,
                                   // inverse_shift, forward_result, inverse_result
  output logic         out_tuser   // bad_input
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE  = 4'd1;
  localparam logic [3:0] S_TDN  = 4'd2;
  localparam logic [3:0] S_TUP  = 4'd3;
  localparam logic [3:0] S_DIVF = 4'd4;
  localparam logic [3:0] S_INRM = 4'd5;
  localparam logic [3:0] S_DIVI = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]   state_r, state_nxt;
  logic         out_valid_r;
  logic [207:0] out_data_r;
  logic         out_bad_r;

  logic [63:0]  ticks_r, period_r, t_r, delta_r, sd_r, fwd_r, inv_r;
  logic [31:0]  rem_r, quo_r, div_d_r, fmul_r, imul_r, dividend_r, acc_r;
  shift_t       fshift_r, ishift_r;
  logic [4:0]   cnt_r;
  logic         bad_r;

  logic [ALU_W-1:0] alu_a, alu_b;
  alu_res_t         alu_res;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod;
  logic             in_fire, out_load, bad_cond, div_last;
  logic [31:0]      quo_new;

  function automatic logic [63:0] shift_apply(input logic [63:0] d, input shift_t sh);
    logic [9:0] mag;
    mag = sh[9] ? (~sh + 10'd1) : sh;
    if (|mag[9:6]) begin
      return 64'd0;
    end else if (sh[9]) begin
      return d >> mag[5:0];
    end else begin
      return d << mag[5:0];
    end
  endfunction

  tsc_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .res  (alu_res)
  );

  tsc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign bad_cond   = (period_r == 64'd0) || (t_r[31:0] == 32'd0);
  assign div_last   = (cnt_r == 5'd31);
  assign quo_new    = {quo_r[30:0], !alu_res.borrow};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

  // operand select for the shared compare/subtract unit
  always_comb begin
    case (state_r)
      S_PRE: begin
        alu_a = {1'b0, PERIOD_LIMIT};
        alu_b = {1'b0, period_r};
      end
      S_TDN: begin
        alu_a = {period_r, 1'b0};
        alu_b = {1'b0, t_r};
      end
      S_TUP: begin
        alu_a = {1'b0, period_r};
        alu_b = {1'b0, t_r};
      end
      S_DIVF, S_DIVI: begin
        alu_a = {32'd0, rem_r, 1'b0};
        alu_b = {33'd0, div_d_r};
      end
      S_INRM: begin
        alu_a = {33'd0, dividend_r};
        alu_b = {33'd0, fmul_r};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign mul_a = (cnt_r == 5'd2 || cnt_r == 5'd5) ? sd_r[63:32] : sd_r[31:0];
  assign mul_b = (cnt_r <= 5'd3) ? fmul_r : imul_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_PRE;
      S_PRE:  if (!alu_res.borrow) state_nxt = S_TDN;
      S_TDN:  if (!alu_res.borrow) state_nxt = bad_cond ? S_OUT : S_TUP;
      S_TUP:  if (alu_res.borrow) state_nxt = S_DIVF;
      S_DIVF: if (div_last) state_nxt = S_INRM;
      S_INRM: if (alu_res.borrow) state_nxt = S_DIVI;
      S_DIVI: if (div_last) state_nxt = S_MUL;
      S_MUL:  if (cnt_r == 5'd6) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ticks_r  <= in_tdata[63:0];
          period_r <= in_tdata[127:64];
          delta_r  <= in_tdata[191:128];
          fshift_r <= '0;
          bad_r    <= 1'b0;
        end
      end
      // halve both while period is above 2^31
      S_PRE: begin
        if (alu_res.borrow) begin
          ticks_r  <= ticks_r >> 1;
          period_r <= period_r >> 1;
        end else begin
          t_r <= ticks_r;
        end
      end
      // bring ticks down to at most twice the period
      S_TDN: begin
        if (alu_res.borrow) begin
          t_r      <= t_r >> 1;
          fshift_r <= fshift_r - 10'sd1;
        end else if (bad_cond) begin
          bad_r <= 1'b1;
        end else begin
          t_r <= {32'd0, t_r[31:0]};
        end
      end
      // raise ticks above the period
      S_TUP: begin
        if (!alu_res.borrow) begin
          if (t_r[31]) begin
            period_r <= period_r >> 1;
          end else begin
            t_r <= {32'd0, t_r[30:0], 1'b0};
          end
          fshift_r <= fshift_r + 10'sd1;
        end else begin
          rem_r   <= period_r[31:0];
          div_d_r <= t_r[31:0];
          quo_r   <= '0;
          cnt_r   <= '0;
        end
      end
      S_DIVF, S_DIVI: begin
        rem_r <= alu_res.borrow ? alu_a[31:0] : alu_res.diff[31:0];
        quo_r <= quo_new;
        cnt_r <= cnt_r + 5'd1;
        if (div_last) begin
          if (state_r == S_DIVF) begin
            fmul_r     <= quo_new;
            dividend_r <= MUL_IDENTITY;
            ishift_r   <= 10'sd1 - fshift_r;
          end else begin
            imul_r <= quo_new;
          end
        end
      end
      S_INRM: begin
        if (!alu_res.borrow) begin
          dividend_r <= dividend_r >> 1;
          ishift_r   <= ishift_r + 10'sd1;
        end else begin
          rem_r   <= dividend_r;
          div_d_r <= fmul_r;
          quo_r   <= '0;
          cnt_r   <= '0;
        end
      end
      // shift delta, then low and high partial products for each scale
      S_MUL: begin
        cnt_r <= cnt_r + 5'd1;
        case (cnt_r)
          5'd0: sd_r <= shift_apply(delta_r, fshift_r);
          5'd2: acc_r <= prod[63:32];
          5'd3: begin
            fwd_r <= prod + {32'd0, acc_r};
            sd_r  <= shift_apply(delta_r, ishift_r);
          end
          5'd5: acc_r <= prod[63:32];
          5'd6: inv_r <= prod + {32'd0, acc_r};
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_load) begin
          out_bad_r  <= bad_r;
          out_data_r <= bad_r ? '0 :
                        {inv_r, fwd_r, ishift_r[7:0], imul_r, fshift_r[7:0], fmul_r};
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/tsc_alu.sv]
module tsc_alu import tsc_pkg::*; (
  input  logic [ALU_W-1:0] op_a,
  input  logic [ALU_W-1:0] op_b,
  output alu_res_t         res
);

  logic [ALU_W:0] wide;

  // borrow set when op_a < op_b
  assign wide       = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff   = wide[ALU_W-1:0];
  assign res.borrow = wide[ALU_W];

endmodule

[sv/tsc_mul.sv]
module tsc_mul import tsc_pkg::*; (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  assign prod = prod_r;

endmodule
